// File: design/scl_pkg.sv
// Shared constants, types and helpers for the serial command line queue.
package scl_pkg;

    // Ring and line sizes.
    localparam int QUEUE_SLOTS = 4;
    localparam int LINE_BYTES  = 64;

    // Derived widths.
    localparam int SLOT_W  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int IDX_W   = $clog2(LINE_BYTES);
    localparam int POS_W   = $clog2(LINE_BYTES + 1);
    localparam int QADDR_W = $clog2(QUEUE_SLOTS * LINE_BYTES);
    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 7;
    localparam int CMP_W   = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;

    // Command queue between the front and the back.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Characters with a meaning of their own.
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

    // Operation codes of an input request.
    localparam logic IN_OP_BYTE = 1'b0;
    localparam logic IN_OP_READ = 1'b1;

    // Classified commands.
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_LINE  = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op              op;
        logic [BYTE_W-1:0]    data;
        logic [LIMIT_W-1:0]   limit;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              queue_empty;
        logic              last;
    } t_rsp;

    // Advances a ring slot index with wrap-around.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] res;
        if (slot == SLOT_W'(QUEUE_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = slot + SLOT_W'(1);
        end
        return res;
    endfunction

    // Flat queue memory address of one byte of one slot.
    function automatic logic [QADDR_W-1:0] queue_addr(input logic [SLOT_W-1:0] slot,
                                                       input logic [IDX_W-1:0]  idx);
        return QADDR_W'(slot) * QADDR_W'(LINE_BYTES) + QADDR_W'(idx);
    endfunction

endpackage

// File: design/scl_if.sv
// Request and response channel interfaces of the serial command line queue.
interface scl_in_if
    import scl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [BYTE_W-1:0]   rx_byte;
    logic [LIMIT_W-1:0]  read_limit;

    modport source (output valid, output operation, output rx_byte, output read_limit,
                    input ready);
    modport sink   (input valid, input operation, input rx_byte, input read_limit,
                    output ready);
endinterface

interface scl_out_if
    import scl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               queue_empty;
    logic               last;

    modport source (output valid, output out_byte, output byte_valid, output queue_empty,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input queue_empty,
                    input last, output ready);
endinterface

// File: design/scl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module scl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, old data on a clash with a write.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/scl_front.sv
// Front end: accepts requests, drops carriage returns and classifies the rest.
module scl_front
    import scl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    scl_in_if.sink  i_req,
    output logic    o_cmd_valid,
    output t_cmd    o_cmd,
    input  logic    i_cmd_ready
);

    logic   r_cmd_valid;
    t_cmd   r_cmd;
    t_cmd   w_cmd;
    logic   w_accept;
    logic   w_drop;

    assign i_req.ready = !r_cmd_valid || i_cmd_ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Classify the request into a command for the back end.
    always_comb begin
        w_cmd.data  = i_req.rx_byte;
        w_cmd.limit = i_req.read_limit;
        w_cmd.op    = CMD_BYTE;
        w_drop      = 1'b0;
        if (i_req.operation == IN_OP_READ) begin
            w_cmd.op = CMD_READ;
        end else begin
            unique case (i_req.rx_byte)
                CH_CR:   w_drop   = 1'b1;
                CH_PLUS: w_cmd.op = CMD_CLEAR;
                CH_LF:   w_cmd.op = CMD_LINE;
                default: w_cmd.op = CMD_BYTE;
            endcase
        end
    end

    // Output register towards the command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (w_accept) begin
            r_cmd_valid <= !w_drop;
        end else if (i_cmd_ready) begin
            r_cmd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

endmodule

// File: design/scl_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
module scl_cmd_fifo
    import scl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    input  t_cmd  i_wr_cmd,
    output logic  o_wr_ready,
    output logic  o_rd_valid,
    output t_cmd  o_rd_cmd,
    input  logic  i_rd_ready
);

    t_cmd                  r_buf [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  w_push;
    logic                  w_pop;

    // Wraps a queue pointer.
    function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] ptr);
        logic [CMDQ_PTR_W-1:0] res;
        if (ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + CMDQ_PTR_W'(1);
        end
        return res;
    endfunction

    assign o_wr_ready = (r_count != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_buf[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

// File: design/scl_back.sv
// Back end: builds the line, copies finished lines into the ring and replays them.
module scl_back
    import scl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    scl_out_if.source  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TERM = 4'b0010,
        S_COPY = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_wp, n_wp;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [POS_W-1:0]   r_len [QUEUE_SLOTS];
    logic [POS_W-1:0]   r_cidx, n_cidx;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [POS_W-1:0]   r_idx, n_idx;
    logic [POS_W-1:0]   r_bound, n_bound;
    logic [BYTE_W-1:0]  r_hold, n_hold;
    logic               r_hold_valid, n_hold_valid;
    t_rsp               r_rsp, n_rsp;
    logic               r_rsp_valid;

    logic               w_out_free;
    logic               w_push;
    logic               w_take;
    logic               w_len_we;
    logic               w_ring_empty;
    logic               w_ring_full;
    logic               w_cont;
    logic [POS_W-1:0]   w_wp_eff;
    logic [CMP_W-1:0]   w_cap;
    logic [POS_W-1:0]   w_cap_pos;
    logic [POS_W-1:0]   w_slot_len;

    logic               w_st_we;
    logic [IDX_W-1:0]   w_st_waddr;
    logic [BYTE_W-1:0]  w_st_wdata;
    logic [BYTE_W-1:0]  w_st_q;
    logic               w_q_we;
    logic [BYTE_W-1:0]  w_q_q;

    assign w_out_free   = !r_rsp_valid || o_rsp.ready;
    assign w_ring_empty = (r_head == r_tail);
    assign w_ring_full  = (next_slot(r_head) == r_tail);
    assign w_slot_len   = r_len[r_tail];

    // Read limit capped at the line size.
    assign w_cap     = (CMP_W'(i_cmd.limit) > CMP_W'(LINE_BYTES)) ? CMP_W'(LINE_BYTES)
                                                                   : CMP_W'(i_cmd.limit);
    assign w_cap_pos = POS_W'(w_cap);

    // A read of an empty ring waits until the output register can take its result.
    assign o_cmd_ready = (r_state == S_IDLE) &&
                         ((i_cmd.op != CMD_READ) || !w_ring_empty || w_out_free);
    assign w_take      = i_cmd_valid && o_cmd_ready;

    // A byte is sent on while it is in range and not the terminator.
    assign w_cont = (r_idx < r_bound) && (w_q_q != CH_NUL);

    // Sequencer for line building, ring copy and line replay.
    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_head       = r_head;
        n_tail       = r_tail;
        n_cidx       = r_cidx;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_bound      = r_bound;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_rsp        = r_rsp;
        w_push       = 1'b0;
        w_len_we     = 1'b0;
        w_st_we      = 1'b0;
        w_st_waddr   = r_wp[IDX_W-1:0];
        w_st_wdata   = i_cmd.data;
        w_q_we       = 1'b0;
        w_wp_eff     = (i_cmd.op == CMD_CLEAR) ? '0 : r_wp;

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_cmd.op == CMD_READ) begin
                        if (w_ring_empty) begin
                            w_push = 1'b1;
                            n_rsp  = '{out_byte: CH_NUL, byte_valid: 1'b0,
                                       queue_empty: 1'b1, last: 1'b1};
                        end else begin
                            n_slot  = r_tail;
                            n_tail  = next_slot(r_tail);
                            n_idx   = '0;
                            n_bound = (w_cap_pos < w_slot_len) ? w_cap_pos : w_slot_len;
                            n_state = S_EMIT;
                        end
                    end else begin
                        // A plus restarts the line; each kept byte is then appended while the store has room.
                        n_wp = w_wp_eff;
                        if (w_wp_eff < POS_W'(LINE_BYTES - 1)) begin
                            w_st_we    = 1'b1;
                            w_st_waddr = w_wp_eff[IDX_W-1:0];
                            n_wp       = w_wp_eff + POS_W'(1);
                        end
                        if (i_cmd.op == CMD_LINE) begin
                            n_state = S_TERM;
                        end
                    end
                end
            end
            S_TERM: begin
                // Terminator, skipped when the store is already full.
                if (r_wp < POS_W'(LINE_BYTES)) begin
                    w_st_we    = 1'b1;
                    w_st_wdata = CH_NUL;
                    n_wp       = r_wp + POS_W'(1);
                end
                n_cidx  = '0;
                n_state = w_ring_full ? S_IDLE : S_COPY;
            end
            S_COPY: begin
                // One byte a cycle from the line store into the head slot.
                w_q_we = 1'b1;
                if (r_cidx + POS_W'(1) == r_wp) begin
                    w_len_we = 1'b1;
                    n_head   = next_slot(r_head);
                    n_cidx   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_cidx = r_cidx + POS_W'(1);
                end
            end
            S_EMIT: begin
                // One byte is held back so that the final one can be marked.
                if (w_cont) begin
                    if (!r_hold_valid) begin
                        n_hold       = w_q_q;
                        n_hold_valid = 1'b1;
                        n_idx        = r_idx + POS_W'(1);
                    end else if (w_out_free) begin
                        w_push = 1'b1;
                        n_rsp  = '{out_byte: r_hold, byte_valid: 1'b1,
                                   queue_empty: 1'b0, last: 1'b0};
                        n_hold = w_q_q;
                        n_idx  = r_idx + POS_W'(1);
                    end
                end else if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_hold_valid) begin
                        n_rsp = '{out_byte: r_hold, byte_valid: 1'b1,
                                  queue_empty: 1'b0, last: 1'b1};
                    end else begin
                        n_rsp = '{out_byte: CH_NUL, byte_valid: 1'b0,
                                  queue_empty: 1'b0, last: 1'b1};
                    end
                    n_hold_valid = 1'b0;
                    n_idx        = '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_cidx       <= '0;
            r_slot       <= '0;
            r_idx        <= '0;
            r_hold_valid <= 1'b0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_cidx       <= n_cidx;
            r_slot       <= n_slot;
            r_idx        <= n_idx;
            r_hold_valid <= n_hold_valid;
            if (w_push) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bound <= n_bound;
        r_hold  <= n_hold;
        r_rsp   <= n_rsp;
        if (w_len_we) begin
            r_len[r_head] <= r_wp;
        end
    end

    // Line store; its read port follows the copy index.
    scl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_BYTES)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_st_we),
        .i_wr_addr (w_st_waddr),
        .i_wr_data (w_st_wdata),
        .i_rd_addr (n_cidx[IDX_W-1:0]),
        .o_rd_data (w_st_q)
    );

    // Ring of queued lines; its read port follows the replay index.
    scl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_SLOTS * LINE_BYTES)
    ) u_queue_lines (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_we),
        .i_wr_addr (queue_addr(r_head, r_cidx[IDX_W-1:0])),
        .i_wr_data (w_st_q),
        .i_rd_addr (queue_addr(n_slot, n_idx[IDX_W-1:0])),
        .o_rd_data (w_q_q)
    );

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.out_byte    = r_rsp.out_byte;
    assign o_rsp.byte_valid  = r_rsp.byte_valid;
    assign o_rsp.queue_empty = r_rsp.queue_empty;
    assign o_rsp.last        = r_rsp.last;

endmodule

// File: design/serial_command_line_queue_top.sv
// Serial command line queue: front end, command queue and back end.
// A received byte is taken into the line store; a newline then copies the line into the ring,
// one byte a cycle, unless the ring is full. A read answers with an empty-ring report,
// an empty-line report or the line bytes, which follow one a cycle while the receiver is ready.
// Intake stops once the front register and queue are full.
// Synchronous active-low reset empties the line, the ring and all handshake state.
module serial_command_line_queue_top
    import scl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    scl_in_if.sink     i_req,
    scl_out_if.source  o_rsp
);

    logic  w_fc_valid;
    t_cmd  w_fc_cmd;
    logic  w_fc_ready;
    logic  w_cb_valid;
    t_cmd  w_cb_cmd;
    logic  w_cb_ready;

    // Request intake and classification.
    scl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_fc_valid),
        .o_cmd       (w_fc_cmd),
        .i_cmd_ready (w_fc_ready)
    );

    // Decoupling queue.
    scl_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fc_valid),
        .i_wr_cmd   (w_fc_cmd),
        .o_wr_ready (w_fc_ready),
        .o_rd_valid (w_cb_valid),
        .o_rd_cmd   (w_cb_cmd),
        .i_rd_ready (w_cb_ready)
    );

    // Line building, ring copy and replay.
    scl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cb_valid),
        .i_cmd       (w_cb_cmd),
        .o_cmd_ready (w_cb_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// File: design/scl_checker.sv
// Port-level checks of the serial command line queue, bound to the top level.
module scl_checker
    import scl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rsp_valid,
    input  logic               i_rsp_ready,
    input  logic [BYTE_W-1:0]  i_out_byte,
    input  logic               i_byte_valid,
    input  logic               i_queue_empty,
    input  logic               i_last
);

    // An empty-ring report is always the only result of its read.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_queue_empty |-> i_last && !i_byte_valid)
        else $error("empty-ring result not marked final or carries a byte");

    // A result without a line byte carries a zero byte.
    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_byte_valid |-> i_out_byte == CH_NUL)
        else $error("result without a line byte has a non-zero byte");

    // A line byte is never the terminator.
    a_byte_not_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_byte_valid |-> i_out_byte != CH_NUL && !i_queue_empty)
        else $error("line byte is a terminator or flagged as empty");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_out_byte) &&
        $stable(i_byte_valid) && $stable(i_queue_empty) && $stable(i_last))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result pending after reset");

endmodule

bind serial_command_line_queue_top scl_checker u_scl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_out_byte    (o_rsp.out_byte),
    .i_byte_valid  (o_rsp.byte_valid),
    .i_queue_empty (o_rsp.queue_empty),
    .i_last        (o_rsp.last)
);

// File: test/tb_serial_command_line_queue_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial command line queue: framing, ring and read-out.
module tb_serial_command_line_queue_top
    import scl_pkg::*;
;

    // Keeps its own copy of the line store and the ring, and the line bytes each read must return.
    class line_queue_scoreboard;
        logic [BYTE_W-1:0] line_buf [LINE_BYTES];
        logic [BYTE_W-1:0] ring [QUEUE_SLOTS][LINE_BYTES];
        int                fill_pos;
        int                head;
        int                tail;
        t_rsp              awaited_bytes [$];
        int                errors;

        function new();
            foreach (line_buf[i]) line_buf[i] = CH_NUL;
            foreach (ring[s, i]) ring[s][i] = CH_NUL;
            fill_pos = 0;
            head     = 0;
            tail     = 0;
            errors   = 0;
        endfunction

        function int pending();
            return awaited_bytes.size();
        endfunction

        // Framing of one received byte into the line store and, on newline, into the ring.
        function void take_byte(logic [BYTE_W-1:0] b);
            if (b == CH_CR) begin
                return;
            end
            if (b == CH_PLUS) begin
                fill_pos = 0;
                foreach (line_buf[i]) line_buf[i] = CH_NUL;
            end
            if (fill_pos < LINE_BYTES - 1) begin
                line_buf[fill_pos] = b;
                fill_pos++;
            end
            if (b == CH_LF) begin
                // The terminator is skipped once the store is already full.
                if (fill_pos < LINE_BYTES) begin
                    line_buf[fill_pos] = CH_NUL;
                    fill_pos++;
                end
                // A full ring drops the line without a word.
                if ((head + 1) % QUEUE_SLOTS != tail) begin
                    for (int i = 0; i < LINE_BYTES; i++) ring[head][i] = line_buf[i];
                    head = (head + 1) % QUEUE_SLOTS;
                end
            end
        endfunction

        // Pops the oldest line and lists the bytes that the read must return.
        function void pop_line(logic [LIMIT_W-1:0] lim);
            t_rsp rsp;
            int   slot;
            int   cap;
            int   n;
            rsp = '0;
            n   = 0;
            if (head == tail) begin
                rsp.queue_empty = 1'b1;
                rsp.last        = 1'b1;
                awaited_bytes.push_back(rsp);
                return;
            end
            slot = tail;
            tail = (tail + 1) % QUEUE_SLOTS;
            cap  = (int'(lim) < LINE_BYTES) ? int'(lim) : LINE_BYTES;
            for (int i = 0; i < cap && ring[slot][i] != CH_NUL; i++) begin
                rsp.out_byte   = ring[slot][i];
                rsp.byte_valid = 1'b1;
                awaited_bytes.push_back(rsp);
                n++;
            end
            if (n == 0) begin
                rsp      = '0;
                rsp.last = 1'b1;
                awaited_bytes.push_back(rsp);
            end else begin
                awaited_bytes[awaited_bytes.size() - 1].last = 1'b1;
            end
        endfunction

        function void note_request(logic op, logic [BYTE_W-1:0] b, logic [LIMIT_W-1:0] lim);
            if (op == IN_OP_BYTE) begin
                take_byte(b);
            end else begin
                pop_line(lim);
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited_bytes.size() == 0) begin
                $error("unexpected response: out_byte %0h byte_valid %0b queue_empty %0b last %0b",
                       got.out_byte, got.byte_valid, got.queue_empty, got.last);
                errors++;
                return;
            end
            want = awaited_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.queue_empty !== want.queue_empty) begin
                $error("queue_empty: expected %0b, got %0b", want.queue_empty, got.queue_empty);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    int   items_sent;

    scl_in_if  req_if ();
    scl_out_if rsp_if ();

    line_queue_scoreboard sb = new();

    serial_command_line_queue_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // All inputs known from the start.
    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.operation  = IN_OP_BYTE;
        req_if.rx_byte    = '0;
        req_if.read_limit = '0;
        rsp_if.ready      = 1'b0;
        calm              = 1'b0;
        items_sent        = 0;
    end

    // The receiver stalls at random outside the calm stretch.
    always @(negedge i_clk) begin
        rsp_if.ready <= calm || ($urandom_range(99, 0) >= 24);
    end

    // Accepted requests and responses are observed at the rising edge.
    always @(posedge i_clk) begin
        t_rsp got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.operation, req_if.rx_byte, req_if.read_limit);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.out_byte    = rsp_if.out_byte;
                got.byte_valid  = rsp_if.byte_valid;
                got.queue_empty = rsp_if.queue_empty;
                got.last        = rsp_if.last;
                sb.check_result(got);
            end
        end
    end

    // Presents one request and holds it until accepted; valid stays high for a following request.
    task automatic send_req(logic op, logic [BYTE_W-1:0] b, logic [LIMIT_W-1:0] lim);
        @(negedge i_clk);
        while (!calm && $urandom_range(99, 0) < 24) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        // The unused field carries noise.
        req_if.rx_byte    <= (op == IN_OP_BYTE) ? b : BYTE_W'($urandom_range(255, 0));
        req_if.read_limit <= (op == IN_OP_READ) ? lim : LIMIT_W'($urandom_range(127, 0));
        do @(posedge i_clk); while (!req_if.ready);
        if (op == IN_OP_READ || b != CH_CR) begin
            items_sent++;
        end
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        send_req(IN_OP_BYTE, b, '0);
    endtask

    task automatic send_read(int lim);
        send_req(IN_OP_READ, '0, LIMIT_W'(lim));
    endtask

    // Holds the sender back until every awaited response has arrived.
    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Line content: mostly printable text, now and then carriage return, zero or any byte.
    function automatic logic [BYTE_W-1:0] text_byte();
        int pick;
        pick = $urandom_range(19, 0);
        if (pick == 0) return CH_CR;
        if (pick == 1) return BYTE_W'($urandom_range(255, 0));
        if (pick == 2) return CH_NUL;
        return BYTE_W'($urandom_range(8'h7E, 8'h2C));
    endfunction

    function automatic int pick_limit();
        if ($urandom_range(3, 0) == 0) return $urandom_range(127, 0);
        return $urandom_range(20, 0);
    endfunction

    // Stimulus.
    initial begin
        int start;
        int pick;
        int len;
        bit first;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty ring, ignored carriage return, clear, position kept after
        // newline, zero limit, ring full, zero byte, high byte and limit beyond the line.
        send_read(64);
        send_byte(CH_PLUS);
        send_byte("h");
        send_byte(CH_CR);
        send_byte("i");
        send_byte(CH_LF);
        send_read(64);
        send_byte("x");
        send_byte(CH_LF);
        send_read(0);
        repeat (4) send_byte(CH_LF);
        send_read(1);
        send_read(127);
        send_read(3);
        send_read(5);
        send_byte(CH_PLUS);
        send_byte(CH_NUL);
        send_byte(CH_LF);
        send_read(64);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_read(100);
        drain();

        // Random part: mostly framed lines with random content, some reads and noise.
        start = items_sent;
        first = 1'b1;
        while (items_sent - start < 250) begin
            calm = (items_sent - start >= 60) && (items_sent - start < 110);
            pick = $urandom_range(99, 0);
            if (first || pick < 8) begin
                // Long line that can fill the store, then a second newline, on a full store when it does.
                send_byte(CH_PLUS);
                len = $urandom_range(70, 58);
                repeat (len) send_byte(text_byte());
                send_byte(CH_LF);
                send_byte(CH_LF);
                send_read($urandom_range(127, 60));
            end else if (pick < 65) begin
                if ($urandom_range(3, 0) != 0) send_byte(CH_PLUS);
                len = $urandom_range(12, 0);
                repeat (len) send_byte(text_byte());
                send_byte(CH_LF);
                if ($urandom_range(1, 0) == 0) send_read(pick_limit());
            end else if (pick < 82) begin
                send_read(pick_limit());
            end else begin
                send_byte(BYTE_W'($urandom_range(255, 0)));
            end
            first = 1'b0;
            if ($urandom_range(29, 0) == 0) drain();
        end
        calm = 1'b0;

        // Let the last responses arrive and any line copy finish.
        drain();
        repeat (LINE_BYTES + 16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS serial_command_line_queue_top");
        end else begin
            $display("FAIL serial_command_line_queue_top");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("FAIL serial_command_line_queue_top");
        $finish;
    end

endmodule

// File: files.f
design/scl_pkg.sv
design/scl_if.sv
design/scl_ram.sv
design/scl_front.sv
design/scl_cmd_fifo.sv
design/scl_back.sv
design/serial_command_line_queue_top.sv
design/scl_checker.sv
test/tb_serial_command_line_queue_top.sv
